[rtl/scg_pkg.sv]
package scg_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int MAX_LENGTH    = 4096;

  localparam int TAP_W   = 12;
  localparam int VAL_W   = 18;
  localparam int CUT_W   = 16;
  localparam int LEN_W   = 13;
  localparam int CFG_W   = 16;
  localparam int HABS_W  = 13;
  localparam int P_W     = 29;
  localparam int DEN_W   = 61;
  localparam int REM_W   = 62;
  localparam int Q_W     = 20;
  localparam int DIV_STEPS = 16 + FRACTION_BITS;
  localparam int HORNER_STEPS = 5;

  localparam logic [CUT_W-1:0] CUTOFF_RESET = 16'd4096;
  localparam logic [CUT_W-1:0] CUTOFF_HALF  = 16'd32768;
  localparam logic [LEN_W-1:0] LENGTH_RESET = 13'd64;
  localparam logic [LEN_W-1:0] LENGTH_MAX   = LEN_W'(MAX_LENGTH);
  localparam logic [31:0]      PI_Q30       = 32'd3373259426;

  localparam logic [0:0] CFG_CUTOFF = 1'b0;
  localparam logic [0:0] CFG_KLEN   = 1'b1;

  typedef logic signed [32:0] q30_t;

  localparam q30_t SINE_POLY [HORNER_STEPS+1] = '{
    -33'sd3864, 33'sd172272, -33'sd5026996, 33'sd85569305,
    -33'sd693598668, 33'sd1686629713
  };

  typedef struct packed {
    logic signed [VAL_W-1:0] prior;
    logic                    pzero;
    logic                    sneg;
    logic [30:0]             u;
    logic [DEN_W-1:0]        den;
  } hside_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] prior;
    logic                    pzero;
    logic                    sneg;
    logic [DEN_W-1:0]        den;
  } dside_t;

  // Q30 product, rounded half away from zero
  function automatic q30_t mul_q30(input q30_t a, input q30_t b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] m;
    q30_t        r;
    ma = a[32] ? 32'(-a) : 32'(a);
    mb = b[32] ? 32'(-b) : 32'(b);
    m  = {32'b0, ma} * {32'b0, mb} + 64'h2000_0000;
    r  = q30_t'(m[62:30]);
    return (a[32] ^ b[32]) ? -r : r;
  endfunction

endpackage

[rtl/scg_if.sv]
interface scg_in_if;
  import scg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [TAP_W-1:0]        tap_index;
  logic signed [VAL_W-1:0] prior_value;
  modport source (output valid, tap_index, prior_value, input ready);
  modport sink (input valid, tap_index, prior_value, output ready);
endinterface

interface scg_out_if;
  import scg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] coefficient;
  logic                    saturated;
  modport source (output valid, coefficient, saturated, input ready);
  modport sink (input valid, coefficient, saturated, output ready);
endinterface

[rtl/scg_horner_cell.sv]
module scg_horner_cell import scg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  q30_t   coef_i,
  input  q30_t   acc_i,
  input  q30_t   u2_i,
  input  hside_t side_i,
  output logic   valid_o,
  input  logic   ready_i,
  output q30_t   acc_o,
  output q30_t   u2_o,
  output hside_t side_o
);

  logic   v_q;
  q30_t   acc_q, u2_q;
  hside_t side_q;
  logic   ld;

  assign ld      = !v_q || ready_i;
  assign ready_o = ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ld) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld && valid_i) begin
      acc_q  <= coef_i + mul_q30(acc_i, u2_i);
      u2_q   <= u2_i;
      side_q <= side_i;
    end
  end

  assign valid_o = v_q;
  assign acc_o   = acc_q;
  assign u2_o    = u2_q;
  assign side_o  = side_q;

endmodule

[rtl/scg_div_cell.sv]
module scg_div_cell import scg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [REM_W-1:0] rem_i,
  input  logic [Q_W-1:0]   q_i,
  input  dside_t           side_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [REM_W-1:0] rem_o,
  output logic [Q_W-1:0]   q_o,
  output dside_t           side_o
);

  logic             v_q;
  logic [REM_W-1:0] rem_q;
  logic [Q_W-1:0]   q_q;
  dside_t           side_q;
  logic             ld;
  logic [REM_W:0]   rem2;
  logic [REM_W:0]   den_x;
  logic             ge;

  assign ld      = !v_q || ready_i;
  assign ready_o = ld;
  assign rem2    = {rem_i, 1'b0};
  assign den_x   = (REM_W+1)'(side_i.den);
  assign ge      = rem2 >= den_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ld) begin
      v_q <= valid_i;
    end
  end

  // one restoring step
  always_ff @(posedge clk_i) begin
    if (ld && valid_i) begin
      rem_q  <= ge ? REM_W'(rem2 - den_x) : rem2[REM_W-1:0];
      q_q    <= {q_i[Q_W-2:0], ge};
      side_q <= side_i;
    end
  end

  assign valid_o = v_q;
  assign rem_o   = rem_q;
  assign q_o     = q_q;
  assign side_o  = side_q;

endmodule

[rtl/sinc_coefficient_generator.sv]
// One tap of a symmetric sinc low-pass kernel plus a prior sample, saturated.
// Fully pipelined: one request per cycle while the output is taken.
// The pipeline is four front stages, five Horner cells for the sine, one
// stage for the last sine product, the 32-cell restoring divider chain
// (one quotient bit per cell) and the output register. Stages stall
// individually, so bubbles drain while the output is held.
module sinc_coefficient_generator import scg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  scg_in_if.sink           in_if,
  scg_out_if.source        out_if,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [CUT_W-1:0] cutoff_q;
  logic [LEN_W-1:0] klen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RESET;
      klen_q   <= LENGTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CUTOFF: cutoff_q <= cfg_data_i;
        CFG_KLEN:   klen_q   <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CUT_W-1:0] c_eff;
  logic [LEN_W-1:0] n_eff;
  assign c_eff = (cutoff_q > CUTOFF_HALF) ? CUTOFF_HALF : cutoff_q;
  always_comb begin
    n_eff = klen_q;
    if (klen_q == '0) n_eff = LEN_W'(1);
    else if (klen_q > LENGTH_MAX) n_eff = LENGTH_MAX;
  end

  logic ld1, ld2, ld3, ld4, ld5, ld_o;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;
  logic [HORNER_STEPS:0] hv, hrdy;
  logic [DIV_STEPS:0]    dv, drdy;

  // stage 1: distance from centre, doubled
  logic signed [14:0]       h;
  logic [HABS_W-1:0]        habs_q;
  logic signed [VAL_W-1:0]  prior1_q;
  assign h = $signed({2'b0, in_if.tap_index, 1'b0}) - $signed({2'b0, n_eff}) + 15'sd1;

  assign ld1         = !v1_q || ld2;
  assign in_if.ready = ld1;

  always_ff @(posedge clk_i) begin
    if (ld1 && in_if.valid) begin
      habs_q   <= h[14] ? HABS_W'(-h) : HABS_W'(h);
      prior1_q <= in_if.prior_value;
    end
  end

  // stage 2: phase
  logic [P_W-1:0]          p_q;
  logic signed [VAL_W-1:0] prior2_q;
  assign ld2 = !v2_q || ld3;
  always_ff @(posedge clk_i) begin
    if (ld2 && v1_q) begin
      p_q      <= P_W'({13'b0, c_eff} * {16'b0, habs_q});
      prior2_q <= prior1_q;
    end
  end

  // stage 3: quadrant fold and divisor
  logic [1:0]  quad;
  logic [15:0] rf;
  hside_t      s3_q;
  assign quad = p_q[16:15];
  assign rf   = quad[0] ? (16'd32768 - {1'b0, p_q[14:0]}) : {1'b0, p_q[14:0]};
  assign ld3  = !v3_q || ld4;
  always_ff @(posedge clk_i) begin
    if (ld3 && v2_q) begin
      s3_q.prior <= prior2_q;
      s3_q.pzero <= (p_q == '0);
      s3_q.sneg  <= quad[1];
      s3_q.u     <= {rf, 15'b0};
      s3_q.den   <= DEN_W'({29'b0, PI_Q30} * {32'b0, p_q});
    end
  end

  // stage 4: u squared
  q30_t   u2_q;
  hside_t s4_q;
  assign ld4 = !v4_q || hrdy[0];
  always_ff @(posedge clk_i) begin
    if (ld4 && v3_q) begin
      u2_q <= mul_q30(q30_t'({2'b0, s3_q.u}), q30_t'({2'b0, s3_q.u}));
      s4_q <= s3_q;
    end
  end

  q30_t   hacc  [HORNER_STEPS+1];
  q30_t   hu2   [HORNER_STEPS+1];
  hside_t hside [HORNER_STEPS+1];
  assign hv[0]    = v4_q;
  assign hacc[0]  = SINE_POLY[0];
  assign hu2[0]   = u2_q;
  assign hside[0] = s4_q;

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    scg_horner_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (hv[k]),
      .ready_o (hrdy[k]),
      .coef_i  (SINE_POLY[k+1]),
      .acc_i   (hacc[k]),
      .u2_i    (hu2[k]),
      .side_i  (hside[k]),
      .valid_o (hv[k+1]),
      .ready_i (hrdy[k+1]),
      .acc_o   (hacc[k+1]),
      .u2_o    (hu2[k+1]),
      .side_o  (hside[k+1])
    );
  end
  assign hrdy[HORNER_STEPS] = ld5;

  // stage 5: last sine product, clamp to [0, 1.0]
  q30_t              sprod;
  logic [REM_W-1:0]  ms_q;
  dside_t            s5_q;
  assign sprod = mul_q30(hacc[HORNER_STEPS], q30_t'({2'b0, hside[HORNER_STEPS].u}));
  assign ld5   = !v5_q || drdy[0];
  always_ff @(posedge clk_i) begin
    if (ld5 && hv[HORNER_STEPS]) begin
      if (sprod[32]) ms_q <= '0;
      else if (sprod > q30_t'(33'sd1073741824)) ms_q <= REM_W'(1) << 30;
      else ms_q <= REM_W'(sprod[31:0]);
      s5_q.prior <= hside[HORNER_STEPS].prior;
      s5_q.pzero <= hside[HORNER_STEPS].pzero;
      s5_q.sneg  <= hside[HORNER_STEPS].sneg;
      s5_q.den   <= hside[HORNER_STEPS].den;
    end
  end

  logic [REM_W-1:0] drem  [DIV_STEPS+1];
  logic [Q_W-1:0]   dq    [DIV_STEPS+1];
  dside_t           dside [DIV_STEPS+1];
  assign dv[0]    = v5_q;
  assign drem[0]  = ms_q;
  assign dq[0]    = '0;
  assign dside[0] = s5_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    scg_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[k]),
      .ready_o (drdy[k]),
      .rem_i   (drem[k]),
      .q_i     (dq[k]),
      .side_i  (dside[k]),
      .valid_o (dv[k+1]),
      .ready_i (drdy[k+1]),
      .rem_o   (drem[k+1]),
      .q_o     (dq[k+1]),
      .side_o  (dside[k+1])
    );
  end
  assign drdy[DIV_STEPS] = ld_o;

  // output: round, sign, add prior, saturate
  dside_t                  fs;
  logic [REM_W-1:0]        fden;
  logic                    rnd;
  logic [Q_W:0]            qr;
  logic signed [Q_W+1:0]   y;
  logic signed [Q_W+1:0]   sum;
  logic signed [VAL_W-1:0] coef_q;
  logic                    sat_q;

  assign fs   = dside[DIV_STEPS];
  assign fden = REM_W'(fs.den);
  assign rnd  = drem[DIV_STEPS] >= (fden - drem[DIV_STEPS]);
  assign qr   = {1'b0, dq[DIV_STEPS]} + (Q_W+1)'(rnd);
  always_comb begin
    if (fs.pzero) y = (Q_W+2)'(1) <<< FRACTION_BITS;
    else if (fs.sneg) y = -$signed({1'b0, qr});
    else y = $signed({1'b0, qr});
  end
  assign sum  = (Q_W+2)'(fs.prior) + y;
  assign ld_o = !ov_q || out_if.ready;

  always_ff @(posedge clk_i) begin
    if (ld_o && dv[DIV_STEPS]) begin
      if (sum > (Q_W+2)'(131071)) begin
        coef_q <= 18'sd131071;
        sat_q  <= 1'b1;
      end else if (sum < -(Q_W+2)'(131072)) begin
        coef_q <= -18'sd131072;
        sat_q  <= 1'b1;
      end else begin
        coef_q <= VAL_W'(sum);
        sat_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (ld1)  v1_q <= in_if.valid;
      if (ld2)  v2_q <= v1_q;
      if (ld3)  v3_q <= v2_q;
      if (ld4)  v4_q <= v3_q;
      if (ld5)  v5_q <= hv[HORNER_STEPS];
      if (ld_o) ov_q <= dv[DIV_STEPS];
    end
  end

  assign out_if.valid       = ov_q;
  assign out_if.coefficient = coef_q;
  assign out_if.saturated   = sat_q;

endmodule

[rtl/scg_checker.sv]
module scg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [17:0] coef_i,
  input logic        sat_i
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(coef_i) && $stable(sat_i))
    else $error("output request changed while stalled");

  // saturation flag only with a value pinned at a bound
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sat_i |-> coef_i == 18'h1FFFF || coef_i == 18'h20000)
    else $error("saturated without a bound value");

  // pipeline never blocks input while the output stage is empty
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid after reset");

  // an idle input for the whole pipeline depth is not required; a stalled
  // input with a held output is expected, not with the output draining
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while output drains");

endmodule

bind sinc_coefficient_generator scg_checker u_scg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .coef_i      (out_if.coefficient),
  .sat_i       (out_if.saturated)
);
